>>> rtl/core/smtp_body_line_cleanup_top_macros.svh
// Assertion helpers for the line cleanup block.
`ifndef SMTP_BODY_LINE_CLEANUP_TOP_MACROS_SVH
`define SMTP_BODY_LINE_CLEANUP_TOP_MACROS_SVH

// same-cycle implication
`define SBLC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SBLC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/sblc_pkg.sv
`default_nettype none

package sblc_pkg;

    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_DOT = 8'h2E;
    localparam logic [7:0] CH_R   = 8'h52;

    localparam int PREFIX_LEN = 12;
    localparam int CNT_W      = $clog2(PREFIX_LEN + 1);

    // header phase codes
    localparam logic [1:0] HP_TEXT = 2'd0;
    localparam logic [1:0] HP_LF   = 2'd1;
    localparam logic [1:0] HP_LFCR = 2'd2;
    localparam logic [1:0] HP_BODY = 2'd3;

    // line skip codes
    localparam logic [1:0] SK_COPY  = 2'd0;
    localparam logic [1:0] SK_DROP  = 2'd1;
    localparam logic [1:0] SK_MATCH = 2'd2;

    // pending result slots, in emission order
    localparam int PD_OWE   = 0;
    localparam int PD_DOT   = 1;
    localparam int PD_FLUSH = 2;
    localparam int PD_CR    = 3;
    localparam int PD_BYTE  = 4;
    localparam int PD_TAIL  = 5;
    localparam int PD_EMPTY = 6;
    localparam int PD_N     = 7;

    // state bit k+1 matches pending slot k
    typedef enum logic [PD_N:0] {
        S_IDLE  = 8'b0000_0001,
        S_OWE   = 8'b0000_0010,
        S_DOT   = 8'b0000_0100,
        S_FLUSH = 8'b0000_1000,
        S_CR    = 8'b0001_0000,
        S_BYTE  = 8'b0010_0000,
        S_TAIL  = 8'b0100_0000,
        S_EMPTY = 8'b1000_0000
    } state_t;

    typedef struct packed {
        logic   load;
        logic   push;
        logic   last_res;
        logic   flush_step;
        state_t slot;
    } cmd_t;

    typedef struct packed {
        logic            out_free;
        logic            flush_last;
        logic [PD_N-1:0] pend_reg;
        logic [PD_N-1:0] pend_next;
    } status_t;

    function automatic logic [7:0] fold(input logic [7:0] b);
        logic [7:0] r;
        r = b;
        if (b >= 8'h61 && b <= 8'h7A) begin
            r = b - 8'd32;
        end
        return r;
    endfunction

    // "RETURN-PATH:"
    function automatic logic [7:0] rp_char(input logic [CNT_W-1:0] idx);
        logic [7:0] c;
        unique case (idx)
            4'd0:    c = 8'h52;
            4'd1:    c = 8'h45;
            4'd2:    c = 8'h54;
            4'd3:    c = 8'h55;
            4'd4:    c = 8'h52;
            4'd5:    c = 8'h4E;
            4'd6:    c = 8'h2D;
            4'd7:    c = 8'h50;
            4'd8:    c = 8'h41;
            4'd9:    c = 8'h54;
            4'd10:   c = 8'h48;
            4'd11:   c = 8'h3A;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/sblc_dpath.sv
`default_nettype none

module sblc_dpath (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic [7:0]       in_byte,
    input  wire logic             in_last,
    input  wire sblc_pkg::cmd_t   cmd,
    output sblc_pkg::status_t     st,
    input  wire logic             m_tready,
    output logic                  m_tvalid,
    output logic [7:0]            m_tdata,
    output logic                  m_tuser,
    output logic                  m_tlast
);

    localparam int CW = sblc_pkg::CNT_W;

    // line state
    logic          held_reg, held_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [7:0]    prev_reg, prev_next;
    logic [1:0]    phase_reg, phase_next;
    logic          ls_reg, ls_next;
    logic [1:0]    skip_reg, skip_next;
    logic          seen_reg, seen_next;

    logic [7:0]    store [sblc_pkg::PREFIX_LEN];
    logic          wr_en;
    logic [CW-1:0] wr_idx;
    logic [7:0]    fbyte_reg;

    // request plan
    logic [sblc_pkg::PD_N-1:0] pend_reg, pend_next;
    logic [7:0]                byte_reg;
    logic [CW-1:0]             fn_reg, fn_next;
    logic                      plast_reg;
    logic [CW-1:0]             fidx_reg, fidx_next;

    logic       ov_reg, ov_next;
    logic [7:0] ob_reg, ob_next;
    logic       oe_reg, oe_next;
    logic       ol_reg, ol_next;

    function automatic logic [1:0] next_phase(input logic [1:0] h, input logic [7:0] b);
        logic [1:0] r;
        unique case (h)
            sblc_pkg::HP_BODY: r = sblc_pkg::HP_BODY;
            sblc_pkg::HP_TEXT: r = (b == sblc_pkg::CH_LF) ? sblc_pkg::HP_LF : sblc_pkg::HP_TEXT;
            sblc_pkg::HP_LF: begin
                if (b == sblc_pkg::CH_LF) r = sblc_pkg::HP_BODY;
                else if (b == sblc_pkg::CH_CR) r = sblc_pkg::HP_LFCR;
                else r = sblc_pkg::HP_TEXT;
            end
            default: r = (b == sblc_pkg::CH_LF) ? sblc_pkg::HP_BODY : sblc_pkg::HP_TEXT;
        endcase
        return r;
    endfunction

    always_comb begin
        logic          is_crlf;
        logic          do_plain;
        logic [CW-1:0] cnt1;
        logic          p_owe, p_dot, p_cr, p_byte, p_tail;

        is_crlf  = (in_byte == sblc_pkg::CH_CR) || (in_byte == sblc_pkg::CH_LF);
        do_plain = 1'b0;
        cnt1     = cnt_reg + CW'(1);
        p_dot    = 1'b0;
        p_cr     = 1'b0;
        p_byte   = 1'b0;
        p_tail   = 1'b0;
        fn_next  = '0;
        wr_en    = 1'b0;
        wr_idx   = cnt_reg;

        held_next  = held_reg;
        cnt_next   = cnt_reg;
        skip_next  = skip_reg;
        ls_next    = ls_reg;

        p_owe = seen_reg && (prev_reg == sblc_pkg::CH_CR) && (skip_reg == sblc_pkg::SK_COPY)
                && (in_byte != sblc_pkg::CH_LF);

        if (held_reg) begin
            held_next = 1'b0;
            skip_next = is_crlf ? sblc_pkg::SK_DROP : sblc_pkg::SK_COPY;
            p_dot     = !is_crlf && (in_byte != sblc_pkg::CH_DOT);
            do_plain  = 1'b1;
        end else if (skip_reg == sblc_pkg::SK_MATCH) begin
            if (cnt_reg < CW'(sblc_pkg::PREFIX_LEN)
                && sblc_pkg::fold(in_byte) == sblc_pkg::rp_char(cnt_reg)) begin
                wr_en = 1'b1;
                if (cnt1 == CW'(sblc_pkg::PREFIX_LEN)) begin
                    skip_next = sblc_pkg::SK_DROP;
                    cnt_next  = '0;
                end else begin
                    cnt_next = cnt1;
                    if (in_last) begin
                        skip_next = sblc_pkg::SK_COPY;
                        fn_next   = cnt1;
                        cnt_next  = '0;
                    end
                end
            end else begin
                skip_next = sblc_pkg::SK_COPY;
                fn_next   = cnt_reg;
                cnt_next  = '0;
                do_plain  = 1'b1;
            end
        end else if (ls_reg && in_byte != sblc_pkg::CH_LF) begin
            ls_next = 1'b0;
            if (phase_reg != sblc_pkg::HP_BODY && sblc_pkg::fold(in_byte) == sblc_pkg::CH_R
                && !in_last) begin
                wr_en     = 1'b1;
                wr_idx    = '0;
                cnt_next  = CW'(1);
                skip_next = sblc_pkg::SK_MATCH;
            end else if (in_byte == sblc_pkg::CH_DOT && !in_last) begin
                held_next = 1'b1;
                skip_next = sblc_pkg::SK_COPY;
            end else begin
                skip_next = sblc_pkg::SK_COPY;
                do_plain  = 1'b1;
            end
        end else begin
            do_plain = 1'b1;
        end

        if (do_plain) begin
            if (skip_next == sblc_pkg::SK_COPY) begin
                p_byte = 1'b1;
                // bare LF gets its CR
                p_cr = (in_byte == sblc_pkg::CH_LF)
                       && (!seen_reg || prev_reg != sblc_pkg::CH_CR);
            end
            if (is_crlf) begin
                ls_next = 1'b1;
            end
        end

        if (in_last) begin
            p_tail = (in_byte == sblc_pkg::CH_CR) && (skip_next == sblc_pkg::SK_COPY);
        end

        pend_next[sblc_pkg::PD_OWE]   = p_owe;
        pend_next[sblc_pkg::PD_DOT]   = p_dot;
        pend_next[sblc_pkg::PD_FLUSH] = (fn_next != '0);
        pend_next[sblc_pkg::PD_CR]    = p_cr;
        pend_next[sblc_pkg::PD_BYTE]  = p_byte;
        pend_next[sblc_pkg::PD_TAIL]  = p_tail;
        pend_next[sblc_pkg::PD_EMPTY] = in_last
            && !(p_owe || p_dot || (fn_next != '0) || p_cr || p_byte || p_tail);

        phase_next = next_phase(phase_reg, in_byte);
        prev_next  = in_byte;
        seen_next  = 1'b1;

        // end of message: back to reset values
        if (in_last) begin
            held_next  = 1'b0;
            cnt_next   = '0;
            prev_next  = '0;
            phase_next = sblc_pkg::HP_LF;
            ls_next    = 1'b1;
            skip_next  = sblc_pkg::SK_COPY;
            seen_next  = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg  <= 1'b0;
            cnt_reg   <= '0;
            prev_reg  <= '0;
            phase_reg <= sblc_pkg::HP_LF;
            ls_reg    <= 1'b1;
            skip_reg  <= sblc_pkg::SK_COPY;
            seen_reg  <= 1'b0;
        end else if (cmd.load) begin
            held_reg  <= held_next;
            cnt_reg   <= cnt_next;
            prev_reg  <= prev_next;
            phase_reg <= phase_next;
            ls_reg    <= ls_next;
            skip_reg  <= skip_next;
            seen_reg  <= seen_next;
        end
    end

    // flush byte is read ahead into a register, at the index fidx_reg takes next
    always_ff @(posedge aclk) begin
        if (cmd.load && wr_en) begin
            store[wr_idx] <= in_byte;
        end
        fbyte_reg <= store[fidx_next];
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            pend_reg  <= pend_next;
            byte_reg  <= in_byte;
            fn_reg    <= fn_next;
            plast_reg <= in_last;
        end
        fidx_reg <= fidx_next;
    end

    always_comb begin
        fidx_next = fidx_reg;
        if (cmd.flush_step) begin
            fidx_next = fidx_reg + CW'(1);
        end
        if (cmd.load) begin
            fidx_next = '0;
        end
    end

    always_comb begin
        ob_next = ob_reg;
        oe_next = oe_reg;
        ol_next = ol_reg;
        ov_next = m_tready ? 1'b0 : ov_reg;
        if (cmd.push) begin
            ov_next = 1'b1;
            oe_next = 1'b0;
            ol_next = cmd.last_res && plast_reg;
            unique case (cmd.slot)
                sblc_pkg::S_OWE:   ob_next = sblc_pkg::CH_LF;
                sblc_pkg::S_DOT:   ob_next = sblc_pkg::CH_DOT;
                sblc_pkg::S_FLUSH: ob_next = fbyte_reg;
                sblc_pkg::S_CR:    ob_next = sblc_pkg::CH_CR;
                sblc_pkg::S_BYTE:  ob_next = byte_reg;
                sblc_pkg::S_TAIL:  ob_next = sblc_pkg::CH_LF;
                sblc_pkg::S_EMPTY: begin
                    ob_next = '0;
                    oe_next = 1'b1;
                end
                default:           ob_next = '0;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ov_reg <= 1'b0;
        end else begin
            ov_reg <= ov_next;
        end
        ob_reg <= ob_next;
        oe_reg <= oe_next;
        ol_reg <= ol_next;
    end

    assign st.out_free   = !ov_reg || m_tready;
    assign st.flush_last = (fidx_reg + CW'(1)) == fn_reg;
    assign st.pend_reg   = pend_reg;
    assign st.pend_next  = pend_next;

    assign m_tvalid = ov_reg;
    assign m_tdata  = ob_reg;
    assign m_tuser  = oe_reg;
    assign m_tlast  = ol_reg;

endmodule

`default_nettype wire

>>> rtl/core/sblc_ctrl.sv
`default_nettype none

module sblc_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire sblc_pkg::status_t st,
    output sblc_pkg::cmd_t         cmd
);

    localparam int SW = sblc_pkg::PD_N + 1;

    sblc_pkg::state_t state_reg, state_next;

    logic [SW-1:0] s_bits;
    logic [SW-1:0] above;
    logic [SW-1:0] cand;
    logic [SW-1:0] after_bits;
    logic [SW-1:0] first_cand;
    logic [SW-1:0] first_bits;
    logic          busy;
    logic          push;
    logic          stay_flush;
    logic          last_res;
    logic          accept;

    assign s_bits     = state_reg;
    // slots strictly after the current one
    assign above      = ~({s_bits[SW-2:0], 1'b0} - SW'(1));
    assign cand       = {st.pend_reg, 1'b0} & above;
    assign after_bits = cand & (~cand + SW'(1));
    assign first_cand = {st.pend_next, 1'b0};
    assign first_bits = first_cand & (~first_cand + SW'(1));

    assign busy       = state_reg != sblc_pkg::S_IDLE;
    assign push       = busy && st.out_free;
    assign stay_flush = (state_reg == sblc_pkg::S_FLUSH) && !st.flush_last;
    assign last_res   = push && !stay_flush && (after_bits == '0);
    assign s_tready   = !busy || last_res;
    assign accept     = s_tvalid && s_tready;

    always_comb begin
        state_next = state_reg;
        if (accept) begin
            state_next = (first_bits == '0) ? sblc_pkg::S_IDLE : sblc_pkg::state_t'(first_bits);
        end else if (push && !stay_flush) begin
            state_next = (after_bits == '0) ? sblc_pkg::S_IDLE : sblc_pkg::state_t'(after_bits);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sblc_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign cmd.load       = accept;
    assign cmd.push       = push;
    assign cmd.last_res   = last_res;
    assign cmd.flush_step = push && (state_reg == sblc_pkg::S_FLUSH);
    assign cmd.slot       = state_reg;

endmodule

`default_nettype wire

>>> rtl/core/smtp_body_line_cleanup_top.sv
// SMTP body line cleanup.
// s_ channel: one raw message byte per request in s_tdata, s_tlast on the final
// byte. m_ channel: cleaned bytes in m_tdata, m_tuser high for a marker request
// that carries no byte, m_tlast on the last request of the message.
// An input byte yields zero to thirteen output requests, one per cycle. The next
// byte is taken in the same cycle as the last output of the current one, so a
// byte producing one output sustains one byte per cycle while m_tready is high;
// a byte producing k > 1 outputs holds the input until its last one is pushed.
// A byte producing nothing (dropped lines, bytes held while matching a
// Return-Path prefix) leaves the block idle. The output register, fed from the
// registered plan, sets the pace. A failed Return-Path match of n held bytes
// releases them as n output requests. Reset (aresetn low, synchronous) returns
// to header line start and empties the output register. A stalled m_tready
// holds the output register and, through it, the input side; nothing is dropped.
`default_nettype none

module smtp_body_line_cleanup_top (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] in_byte
    input  wire logic       s_tlast,
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [7:0] out_byte
    output logic            m_tuser,   // [0] out_empty
    output logic            m_tlast
);

    sblc_pkg::cmd_t    cmd;
    sblc_pkg::status_t st;
    logic              empty_planned;
    logic              bytes_planned;

    sblc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    sblc_dpath u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_byte  (s_tdata),
        .in_last  (s_tlast),
        .cmd      (cmd),
        .st       (st),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    assign empty_planned = cmd.load && st.pend_next[sblc_pkg::PD_EMPTY];
    assign bytes_planned = st.pend_next[sblc_pkg::PD_TAIL:0] != '0;

`include "smtp_body_line_cleanup_top_macros.svh"

    `SBLC_ASSERT_NOW(a_push_free, cmd.push, st.out_free, "push over a held result")
    `SBLC_ASSERT_NOW(a_empty_alone, empty_planned, !bytes_planned, "empty marker with bytes")
    `SBLC_ASSERT_NEXT(a_idle_after, cmd.last_res && !cmd.load, s_tready, "not ready after last")

endmodule

`default_nettype wire

>>> tb/smtp_body_line_cleanup_top_tb.sv
`timescale 1ns / 100ps

module smtp_body_line_cleanup_top_tb;
    import sblc_pkg::*;

    localparam int    STALL_MAX    = 18;
    localparam int    HOLD_CYCLES  = 300;
    localparam int    IDLE_LIMIT   = 4000;
    localparam int    RANDOM_BYTES = 330;
    localparam int    MAX_RESULTS  = 16;
    localparam string RP_TEXT      = "RETURN-PATH:";

    typedef struct packed {
        logic [7:0] data;
        logic       empty;
        logic       last;
    } cleaned_t;

    // Line cleanup predictor plus the queue of cleaned bytes still owed by the block.
    class cleanup_scoreboard;
        cleaned_t   expected_q[$];
        int         errors;
        cleaned_t   step_out[MAX_RESULTS];
        int         n_out;
        logic [7:0] held_byte;
        bit         held_valid;
        logic [7:0] prefix_buf[PREFIX_LEN];
        int         prefix_cnt;
        logic [7:0] prev_byte;
        logic [1:0] phase;
        bit         at_line_start;
        logic [1:0] skip;
        bit         seen_any;

        function new();
            errors = 0;
            clear_state();
        endfunction

        function void clear_state();
            held_byte     = 8'h00;
            held_valid    = 1'b0;
            prefix_cnt    = 0;
            prev_byte     = 8'h00;
            phase         = HP_LF;
            at_line_start = 1'b1;
            skip          = SK_COPY;
            seen_any      = 1'b0;
        endfunction

        function void emit(logic [7:0] b);
            if (n_out < MAX_RESULTS) begin
                step_out[n_out] = '{data: b, empty: 1'b0, last: 1'b0};
                n_out++;
            end
        endfunction

        function logic [7:0] upcase(logic [7:0] b);
            return (b >= 8'h61 && b <= 8'h7A) ? b - 8'd32 : b;
        endfunction

        // blank line ends the header: LF LF or LF CR LF
        function logic [1:0] advance_phase(logic [1:0] h, logic [7:0] b);
            if (h == HP_BODY) return HP_BODY;
            if (h == HP_TEXT) return (b == CH_LF) ? HP_LF : HP_TEXT;
            if (h == HP_LF) return (b == CH_LF) ? HP_BODY : ((b == CH_CR) ? HP_LFCR : HP_TEXT);
            return (b == CH_LF) ? HP_BODY : HP_TEXT;
        endfunction

        function void pass_byte(logic [7:0] b);
            if (skip == SK_COPY) begin
                if (b == CH_LF && (!seen_any || prev_byte != CH_CR)) begin
                    emit(CH_CR);
                    emit(CH_LF);
                end else begin
                    emit(b);
                end
            end
            if (b == CH_CR || b == CH_LF) at_line_start = 1'b1;
        endfunction

        function void flush_prefix();
            for (int i = 0; i < prefix_cnt; i++) emit(prefix_buf[i]);
            prefix_cnt = 0;
        endfunction

        function void note_byte(logic [7:0] b, logic last);
            bit in_hdr;
            n_out  = 0;
            in_hdr = (phase != HP_BODY);
            // LF owed to an emitted CR not followed by LF
            if (seen_any && prev_byte == CH_CR && skip == SK_COPY && b != CH_LF) emit(CH_LF);
            phase = advance_phase(phase, b);
            if (held_valid) begin
                held_valid = 1'b0;
                if (b == CH_CR || b == CH_LF) begin
                    skip = SK_DROP;
                end else if (b == CH_DOT) begin
                    skip = SK_COPY;
                end else begin
                    skip = SK_COPY;
                    emit(held_byte);
                end
                pass_byte(b);
            end else if (skip == SK_MATCH) begin
                if (prefix_cnt < PREFIX_LEN && upcase(b) == RP_TEXT[prefix_cnt]) begin
                    prefix_buf[prefix_cnt] = b;
                    prefix_cnt++;
                    if (prefix_cnt >= PREFIX_LEN) begin
                        skip       = SK_DROP;
                        prefix_cnt = 0;
                    end else if (last) begin
                        skip = SK_COPY;
                        flush_prefix();
                    end
                end else begin
                    skip = SK_COPY;
                    flush_prefix();
                    pass_byte(b);
                end
            end else if (at_line_start && b != CH_LF) begin
                at_line_start = 1'b0;
                if (in_hdr && upcase(b) == CH_R && !last) begin
                    prefix_buf[0] = b;
                    prefix_cnt    = 1;
                    skip          = SK_MATCH;
                end else if (b == CH_DOT && !last) begin
                    held_byte  = b;
                    held_valid = 1'b1;
                    skip       = SK_COPY;
                end else begin
                    skip = SK_COPY;
                    pass_byte(b);
                end
            end else begin
                pass_byte(b);
            end
            prev_byte = b;
            seen_any  = 1'b1;
            if (last) begin
                if (b == CH_CR && skip == SK_COPY) emit(CH_LF);
                if (n_out == 0) begin
                    step_out[0] = '{data: 8'h00, empty: 1'b1, last: 1'b0};
                    n_out       = 1;
                end
                step_out[n_out-1].last = 1'b1;
                clear_state();
            end
            for (int i = 0; i < n_out; i++) expected_q.push_back(step_out[i]);
        endfunction

        task report(string what);
            errors++;
            if (errors <= 100) $display("mismatch: %s", what);
        endtask

        task check_result(logic [7:0] data, logic empty, logic last);
            cleaned_t want;
            if (expected_q.size() == 0) begin
                report($sformatf("unexpected request data=%02h empty=%0b last=%0b",
                                 data, empty, last));
                return;
            end
            want = expected_q.pop_front();
            if (empty !== want.empty)
                report($sformatf("empty flag %0b, want %0b", empty, want.empty));
            if (!want.empty && data !== want.data)
                report($sformatf("byte %02h, want %02h", data, want.data));
            if (last !== want.last)
                report($sformatf("last flag %0b, want %0b (byte %02h)", last, want.last,
                                 want.data));
        endtask
    endclass

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;
    logic       s_tlast  = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tuser;
    logic       m_tlast;

    cleanup_scoreboard sb;
    logic [7:0]        msg_bytes[$];
    int                src_mode  = 0;
    int                sink_mode = 0;
    bit                hold_req  = 1'b0;
    int                idle_cycles = 0;

    smtp_body_line_cleanup_top u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #5 aclk = ~aclk;

    // mode 0: back to back, 1: random gaps, 2: mostly back to back
    function automatic int pick_gap(int mode);
        if (mode == 0) return 0;
        if (mode == 1) return $urandom_range(0, STALL_MAX);
        return ($urandom_range(0, 5) == 0) ? $urandom_range(1, STALL_MAX) : 0;
    endfunction

    function automatic logic [7:0] pick_char();
        case ($urandom_range(0, 7))
            0:       return CH_CR;
            1:       return CH_LF;
            2:       return CH_DOT;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic add_text(int n);
        repeat (n) msg_bytes.push_back(pick_char());
    endtask

    // first n chars of the Return-Path tag, letters in random case
    task automatic add_prefix(int n);
        logic [7:0] c;
        for (int k = 0; k < n; k++) begin
            c = RP_TEXT[k];
            if (c >= 8'h41 && c <= 8'h5A && $urandom_range(0, 1) == 1) c = c | 8'h20;
            msg_bytes.push_back(c);
        end
    endtask

    task automatic push_str(string s);
        for (int k = 0; k < s.len(); k++) msg_bytes.push_back(s[k]);
    endtask

    task automatic make_message();
        int n_lines;
        msg_bytes.delete();
        if ($urandom_range(0, 7) == 0) begin
            add_text($urandom_range(1, 12));
            return;
        end
        n_lines = $urandom_range(1, 6);
        repeat (n_lines) begin
            case ($urandom_range(0, 6))
                0: begin
                    add_prefix(PREFIX_LEN);
                    add_text($urandom_range(0, 4));
                end
                1: begin
                    add_prefix($urandom_range(1, PREFIX_LEN - 1));
                    add_text($urandom_range(1, 3));
                end
                2: msg_bytes.push_back(CH_DOT);
                3: begin
                    msg_bytes.push_back(CH_DOT);
                    msg_bytes.push_back(CH_DOT);
                    add_text($urandom_range(0, 3));
                end
                4: add_text($urandom_range(0, 6));
                5: ;  // blank line
                default: begin
                    msg_bytes.push_back(($urandom_range(0, 1) == 1) ? 8'h72 : CH_R);
                    add_text($urandom_range(0, 4));
                end
            endcase
            case ($urandom_range(0, 9))
                6, 7:    msg_bytes.push_back(CH_LF);
                8:       msg_bytes.push_back(CH_CR);
                9:       ;
                default: begin
                    msg_bytes.push_back(CH_CR);
                    msg_bytes.push_back(CH_LF);
                end
            endcase
        end
        if (msg_bytes.size() == 0) msg_bytes.push_back(pick_char());
    endtask

    task automatic send_byte(logic [7:0] b, logic last);
        int gap;
        gap = pick_gap(src_mode);
        if (gap > 0) begin
            @(negedge aclk) s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        sb.note_byte(b, last);
    endtask

    task automatic send_msg();
        for (int k = 0; k < msg_bytes.size(); k++)
            send_byte(msg_bytes[k], k == msg_bytes.size() - 1);
        msg_bytes.delete();
    endtask

    // stop offering and let every owed request come out
    task automatic drain();
        @(negedge aclk) s_tvalid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge aclk);
    endtask

    // receiver: random stalls, one long hold-off on request
    initial begin : sink
        int gap;
        @(posedge aresetn);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                @(negedge aclk) m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end else begin
                gap = pick_gap(sink_mode);
                if (gap > 0) begin
                    @(negedge aclk) m_tready <= 1'b0;
                    repeat (gap - 1) @(negedge aclk);
                end
            end
            @(negedge aclk) m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            sb.check_result(m_tdata, m_tuser, m_tlast);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        int random_sent;
        int msg_no;
        sb          = new();
        random_sent = 0;
        msg_no      = 0;
        repeat (4) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;

        // directed corner cases, back to back with an eager receiver
        push_str("\nx");   send_msg();  // leading LF
        push_str(".");     send_msg();  // lone final dot
        push_str("..");    send_msg();  // doubled dot at end
        push_str("rEt");   send_msg();  // partial tag cut off by the end
        push_str("\r");    send_msg();  // final CR gets an LF
        push_str(".\r");   send_msg();  // dropped final CR, empty marker
        msg_bytes.push_back(8'h00);
        msg_bytes.push_back(8'hFF);
        send_msg();
        push_str("a\rb\n"); send_msg(); // bare CR and bare LF
        push_str(".\nx");  send_msg();  // dot-only line dropped
        push_str("R");     send_msg();
        drain();

        while (random_sent < RANDOM_BYTES) begin
            msg_no++;
            src_mode  = $urandom_range(0, 2);
            sink_mode = $urandom_range(0, 2);
            if (msg_no == 4) begin
                // sender keeps offering while the receiver holds off
                src_mode = 0;
                hold_req = 1'b1;
            end
            make_message();
            random_sent += msg_bytes.size();
            send_msg();
            if (msg_no % 9 == 0) drain();
        end

        @(negedge aclk) s_tvalid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
